// ===== src/reliable_packet_retry_tracker_unit_defines.svh =====
// Assertion macros shared by the tracker modules.
`ifndef RELIABLE_PACKET_RETRY_TRACKER_UNIT_DEFINES_SVH
`define RELIABLE_PACKET_RETRY_TRACKER_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RPRT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rprt assertion failed");

// Condition that must never hold outside reset.
`define RPRT_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rprt forbidden condition seen");

`endif

// ===== src/rprt_pkg.sv =====
package rprt_pkg;

  localparam int unsigned PendingDepth = 16;
  localparam int unsigned IdxW = $clog2(PendingDepth);
  localparam int unsigned CntW = $clog2(PendingDepth + 1);

  localparam logic [15:0] TimeoutRst = 16'd100;
  localparam logic [3:0]  RetriesRst = 4'd10;

  localparam logic [1:0] OpSend   = 2'd0;
  localparam logic [1:0] OpAck    = 2'd1;
  localparam logic [1:0] OpTick   = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [2:0] AddrTimeout = 3'd0;
  localparam logic [2:0] AddrRetries = 3'd4;

  typedef enum logic [2:0] {
    KindAccepted = 3'd0,
    KindRejected = 3'd1,
    KindAcked    = 3'd2,
    KindResend   = 3'd3,
    KindGivenUp  = 3'd4,
    KindDone     = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StEval,
    StMove
  } state_e;

  // One command word passed from the front to the back.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [15:0] seq;
    logic [15:0] handle;
    logic [10:0] size;
    logic [15:0] ack_number;
    logic [31:0] ack_mask;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } link_t;

endpackage

// ===== src/rprt_front.sv =====
module rprt_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rprt_pkg::cmd_t cmd_i,
  output logic          busy_o,
  output rprt_pkg::cmd_t cmd_o,
  output rprt_pkg::link_t link_o,
  input  logic          take_i
);
  import rprt_pkg::*;

  // Two-entry queue between front and back.
  cmd_t       buf_q [2];
  logic [1:0] fill_q, fill_d;
  logic       rd_q, wr_q;
  logic       push, pop;

  assign busy_o = fill_q[1];
  assign push   = start_i && !fill_q[1];
  assign pop    = take_i && (fill_q != 2'd0);
  assign cmd_o  = buf_q[rd_q];
  assign link_o = '{valid: fill_q != 2'd0, ready: !fill_q[1]};

  always_comb begin
    fill_d = fill_q;
    if (push && !pop) fill_d = fill_q + 2'd1;
    else if (!push && pop) fill_d = fill_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rd_q   <= 1'b0;
      wr_q   <= 1'b0;
    end else begin
      fill_q <= fill_d;
      if (push) wr_q <= !wr_q;
      if (pop) rd_q <= !rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= cmd_i;
  end

  `include "reliable_packet_retry_tracker_unit_defines.svh"
  `RPRT_ASSERT(a_fill_max, clk_i, rst_ni, fill_q <= 2'd2)
  `RPRT_ASSERT(a_no_push_full, clk_i, rst_ni, fill_q[1] |-> !push)
  `RPRT_ASSERT(a_pop_nonempty, clk_i, rst_ni, pop |-> fill_q != 2'd0)
endmodule

// ===== src/rprt_back.sv =====
module rprt_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rprt_pkg::cmd_t  cmd_i,
  input  rprt_pkg::link_t link_i,
  output logic           take_o,
  input  logic [15:0]    timeout_i,
  input  logic [3:0]     max_retries_i,
  output logic           idle_o,
  output logic           res_valid_o,
  output logic [2:0]     kind_o,
  output logic [15:0]    entry_sequence_o,
  output logic [15:0]    entry_handle_o,
  output logic [10:0]    entry_size_o,
  output logic [31:0]    round_trip_ms_o,
  output logic           last_o
);
  import rprt_pkg::*;

  logic [15:0] seq_mem [PendingDepth];
  logic [15:0] hdl_mem [PendingDepth];
  logic [10:0] size_mem [PendingDepth];
  logic [31:0] time_mem [PendingDepth];
  logic [3:0]  retr_mem [PendingDepth];

  state_e state_q, state_d;
  cmd_t   cmd_q;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] tail;

  // Registered read of slot idx_q.
  logic [15:0] r_seq, r_hdl;
  logic [10:0] r_size;
  logic [31:0] r_time;
  logic [3:0]  r_retr;

  // Registered read of tail slot, used for moves.
  logic [15:0] t_seq, t_hdl;
  logic [10:0] t_size;
  logic [31:0] t_time;
  logic [3:0]  t_retr;

  logic [15:0] seq_gap;
  logic [31:0] age;
  logic        hit, due, give;
  logic [4:0]  n_retr;

  logic        res_v_d;
  logic [2:0]  kind_d;
  logic [15:0] oseq_d, ohdl_d;
  logic [10:0] osize_d;
  logic [31:0] ortt_d;
  logic        olast_d;

  logic        wr_en, upd_en, cap_cmd;
  logic [IdxW-1:0] wr_idx;

  // Done word still owed by the scan that just ended.
  logic done_pend_q;

  assign tail    = IdxW'(count_q - CntW'(1));
  assign seq_gap = cmd_q.ack_number - r_seq;
  assign hit     = (seq_gap == 16'd0) ||
                   ((seq_gap[15:5] == 11'd0) && cmd_q.ack_mask[seq_gap[4:0]]);
  assign age     = cmd_q.now_ms - r_time;
  assign due     = age > {16'd0, timeout_i};
  assign n_retr  = {1'b0, r_retr} + 5'd1;
  assign give    = n_retr > {1'b0, max_retries_i};
  assign idle_o  = (state_q == StIdle) && !link_i.valid && !done_pend_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    idx_d   = idx_q;
    take_o  = 1'b0;
    cap_cmd = 1'b0;
    wr_en   = 1'b0;
    upd_en  = 1'b0;
    wr_idx  = idx_q;
    res_v_d = 1'b0;
    kind_d  = KindDone;
    oseq_d  = '0;
    ohdl_d  = '0;
    osize_d = '0;
    ortt_d  = '0;
    olast_d = 1'b0;
    case (state_q)
      StIdle: begin
        // Hold the next word while the owed done word goes out.
        if (link_i.valid && !done_pend_q) begin
          take_o  = 1'b1;
          cap_cmd = 1'b1;
          idx_d   = '0;
          if (cmd_i.opcode == OpSend) begin
            res_v_d = 1'b1;
            olast_d = 1'b1;
            oseq_d  = cmd_i.seq;
            ohdl_d  = cmd_i.handle;
            osize_d = cmd_i.size;
            if (count_q == CntW'(PendingDepth)) begin
              kind_d = KindRejected;
            end else begin
              kind_d  = KindAccepted;
              wr_en   = 1'b1;
              wr_idx  = IdxW'(count_q);
              count_d = count_q + CntW'(1);
            end
          end else if ((cmd_i.opcode == OpAck || cmd_i.opcode == OpTick) &&
                       count_q != '0) begin
            state_d = StRead;
          end else begin
            res_v_d = 1'b1;
            olast_d = 1'b1;
          end
        end
      end
      StRead: state_d = StEval;
      StEval: begin
        state_d = StRead;
        oseq_d  = r_seq;
        ohdl_d  = r_hdl;
        osize_d = r_size;
        if (cmd_q.opcode == OpAck && hit) begin
          res_v_d = 1'b1;
          kind_d  = KindAcked;
          ortt_d  = age;
          state_d = StMove;
        end else if (cmd_q.opcode == OpTick && due && give) begin
          res_v_d = 1'b1;
          kind_d  = KindGivenUp;
          state_d = StMove;
        end else begin
          if (cmd_q.opcode == OpTick && due) begin
            res_v_d = 1'b1;
            kind_d  = KindResend;
            upd_en  = 1'b1;
          end
          // Advance to the next slot or finish.
          if (CntW'(idx_q) + CntW'(1) >= count_q) begin
            state_d = StIdle;
            // Done follows next cycle when a result went out now.
          end
          idx_d = idx_q + IdxW'(1);
        end
      end
      StMove: begin
        // Pull the tail entry into the freed slot and recheck it.
        wr_en   = 1'b1;
        count_d = count_q - CntW'(1);
        if (CntW'(idx_q) >= count_q - CntW'(1)) state_d = StIdle;
        else state_d = StRead;
      end
      default: state_d = StIdle;
    endcase
  end

  // Done word is due when a scan returns to idle; it waits behind a result issued then.
  logic scan_end;
  assign scan_end = (state_q != StIdle) && (state_d == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_cmd) cmd_q <= cmd_i;
    r_seq  <= seq_mem[idx_q];
    r_hdl  <= hdl_mem[idx_q];
    r_size <= size_mem[idx_q];
    r_time <= time_mem[idx_q];
    r_retr <= retr_mem[idx_q];
    t_seq  <= seq_mem[tail];
    t_hdl  <= hdl_mem[tail];
    t_size <= size_mem[tail];
    t_time <= time_mem[tail];
    t_retr <= retr_mem[tail];
    if (wr_en && state_q == StIdle) begin
      seq_mem[wr_idx]  <= cmd_i.seq;
      hdl_mem[wr_idx]  <= cmd_i.handle;
      size_mem[wr_idx] <= cmd_i.size;
      time_mem[wr_idx] <= cmd_i.now_ms;
      retr_mem[wr_idx] <= '0;
    end else if (wr_en) begin
      seq_mem[wr_idx]  <= t_seq;
      hdl_mem[wr_idx]  <= t_hdl;
      size_mem[wr_idx] <= t_size;
      time_mem[wr_idx] <= t_time;
      retr_mem[wr_idx] <= t_retr;
    end else if (upd_en) begin
      time_mem[wr_idx] <= cmd_q.now_ms;
      retr_mem[wr_idx] <= n_retr[3:0];
    end
  end

  // Result register with a one-deep pending done word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_o <= 1'b0;
      done_pend_q <= 1'b0;
    end else begin
      res_valid_o <= res_v_d || done_pend_q || (scan_end && !res_v_d);
      done_pend_q <= scan_end && res_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_pend_q || (scan_end && !res_v_d)) begin
      kind_o           <= KindDone;
      entry_sequence_o <= '0;
      entry_handle_o   <= '0;
      entry_size_o     <= '0;
      round_trip_ms_o  <= '0;
      last_o           <= 1'b1;
    end else begin
      kind_o           <= kind_d;
      entry_sequence_o <= oseq_d;
      entry_handle_o   <= ohdl_d;
      entry_size_o     <= osize_d;
      round_trip_ms_o  <= ortt_d;
      last_o           <= olast_d;
    end
  end

  `include "reliable_packet_retry_tracker_unit_defines.svh"
  `RPRT_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CntW'(PendingDepth))
  `RPRT_ASSERT(a_move_shrinks, clk_i, rst_ni,
    state_q == StMove |=> count_q == $past(count_q) - CntW'(1))
  `RPRT_ASSERT(a_done_after, clk_i, rst_ni, done_pend_q |-> state_q == StIdle)
  `RPRT_ASSERT_NEVER(a_no_take_pend, clk_i, rst_ni, take_o && done_pend_q)
endmodule

// ===== src/reliable_packet_retry_tracker_unit.sv =====
// Retry tracker for reliable packets of one connection.
// Commands: start with opcode_i (send, ack, tick) and fields; accepted at
// a clock edge with start high and busy low. A two-word queue parts the
// command side from the table walker, so busy rises only when it is full.
// Results: result_valid_o strobes at most one word per cycle with kind_o,
// entry fields, round_trip_ms_o and last_o; the receiver cannot stall them.
// Send: one result, passed from the queue through the walker to the result
// register. Ack/tick: each table slot is read (registered), then evaluated;
// a removal adds a step that moves the tail entry in; then a done word with
// last_o. The walker over the single table works on one command at a time;
// the queue holds up to two more. Configuration: APB writes to retry_timeout
// (0x0) and max_retries (0x4); the user must write them only while idle, the
// block does not enforce it. Reset empties the table and loads 100 and 10.
module reliable_packet_retry_tracker_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] now_ms_i,
  input  logic [15:0] sequence_number_i,
  input  logic [15:0] payload_handle_i,
  input  logic [10:0] payload_size_i,
  input  logic [15:0] ack_number_i,
  input  logic [31:0] ack_mask_i,
  output logic        result_valid_o,
  output logic [2:0]  kind_o,
  output logic [15:0] entry_sequence_o,
  output logic [15:0] entry_handle_o,
  output logic [10:0] entry_size_o,
  output logic [31:0] round_trip_ms_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rprt_pkg::*;

  cmd_t        cmd_in, cmd_q;
  link_t       link;
  logic        take, idle;
  logic [15:0] timeout_q;
  logic [3:0]  retries_q;

  assign cmd_in = '{opcode: opcode_i, now_ms: now_ms_i, seq: sequence_number_i,
                    handle: payload_handle_i, size: payload_size_i,
                    ack_number: ack_number_i, ack_mask: ack_mask_i};
  assign pready = 1'b1;

  always_comb begin
    case (paddr)
      AddrTimeout: prdata = {16'd0, timeout_q};
      AddrRetries: prdata = {28'd0, retries_q};
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutRst;
      retries_q <= RetriesRst;
    end else if (psel && penable && pwrite) begin
      if (paddr == AddrTimeout) timeout_q <= pwdata[15:0];
      else if (paddr == AddrRetries) retries_q <= pwdata[3:0];
    end
  end

  rprt_front u_front (
    .clk_i, .rst_ni, .start_i(start), .cmd_i(cmd_in), .busy_o(busy),
    .cmd_o(cmd_q), .link_o(link), .take_i(take)
  );

  rprt_back u_back (
    .clk_i, .rst_ni, .cmd_i(cmd_q), .link_i(link), .take_o(take),
    .timeout_i(timeout_q), .max_retries_i(retries_q), .idle_o(idle),
    .res_valid_o(result_valid_o), .kind_o, .entry_sequence_o,
    .entry_handle_o, .entry_size_o, .round_trip_ms_o, .last_o
  );

  `include "reliable_packet_retry_tracker_unit_defines.svh"
  `RPRT_ASSERT(a_cfg_idle, clk_i, rst_ni,
    (psel && penable && pwrite) |-> idle)
  `RPRT_ASSERT(a_pready, clk_i, rst_ni, pready)
  `RPRT_ASSERT(a_last_kind, clk_i, rst_ni,
    (result_valid_o && last_o) |-> (kind_o == KindDone ||
      kind_o == KindAccepted || kind_o == KindRejected))
endmodule

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rprt_pkg::*;

  localparam int unsigned CycleLimit = 2000000;
  localparam int unsigned DrainCycles = 80;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] now;
    logic [15:0] seq;
    logic [15:0] handle;
    logic [10:0] size;
    logic [15:0] ack;
    logic [31:0] mask;
  } cmd_word_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] seq;
    logic [15:0] handle;
    logic [10:0] size;
    logic [31:0] rtt;
    logic        last;
  } result_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0]  opcode_i = '0;
  logic [31:0] now_ms_i = '0;
  logic [15:0] sequence_number_i = '0;
  logic [15:0] payload_handle_i = '0;
  logic [10:0] payload_size_i = '0;
  logic [15:0] ack_number_i = '0;
  logic [31:0] ack_mask_i = '0;
  logic        result_valid_o;
  logic [2:0]  kind_o;
  logic [15:0] entry_sequence_o;
  logic [15:0] entry_handle_o;
  logic [10:0] entry_size_o;
  logic [31:0] round_trip_ms_o;
  logic        last_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  reliable_packet_retry_tracker_unit u_dut (.*);

  always #10 clk_i = ~clk_i;

  // Table model and register copies.
  logic [15:0] tbl_seq [PendingDepth];
  logic [15:0] tbl_handle [PendingDepth];
  logic [10:0] tbl_size [PendingDepth];
  logic [31:0] tbl_sent [PendingDepth];
  logic [3:0]  tbl_retries [PendingDepth];
  int unsigned tbl_count = 0;
  logic [15:0] timeout_reg = TimeoutRst;
  logic [3:0]  retries_reg = RetriesRst;

  cmd_word_t    cmd_queue[$];
  result_word_t expected_results[$];
  int unsigned  mismatches = 0;
  int unsigned  cycles = 0;
  int unsigned  idle_pct = 0;
  bit           taken = 1'b0;

  // Generator state.
  logic [31:0] clock_ms;
  logic [15:0] next_seq;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic void push_result(input kind_e k, input logic [15:0] s,
                                      input logic [15:0] h, input logic [10:0] z,
                                      input logic [31:0] r, input logic l);
    result_word_t w;
    w.kind = k; w.seq = s; w.handle = h; w.size = z; w.rtt = r; w.last = l;
    expected_results.push_back(w);
  endfunction

  function automatic void drop_slot(input int unsigned i);
    int unsigned t;
    t = tbl_count - 1;
    tbl_seq[i] = tbl_seq[t];
    tbl_handle[i] = tbl_handle[t];
    tbl_size[i] = tbl_size[t];
    tbl_sent[i] = tbl_sent[t];
    tbl_retries[i] = tbl_retries[t];
    tbl_count = t;
  endfunction

  function automatic void predict_table(input cmd_word_t c);
    int unsigned i;
    logic [15:0] d;
    logic [31:0] age;
    logic [4:0]  n;
    i = 0;
    if (c.op == OpSend) begin
      if (tbl_count >= PendingDepth) begin
        push_result(KindRejected, c.seq, c.handle, c.size, '0, 1'b1);
      end else begin
        tbl_seq[tbl_count] = c.seq;
        tbl_handle[tbl_count] = c.handle;
        tbl_size[tbl_count] = c.size;
        tbl_sent[tbl_count] = c.now;
        tbl_retries[tbl_count] = '0;
        tbl_count++;
        push_result(KindAccepted, c.seq, c.handle, c.size, '0, 1'b1);
      end
      return;
    end
    if (c.op == OpAck) begin
      while (i < tbl_count) begin
        d = c.ack - tbl_seq[i];
        if (d == 0 || (d < 32 && c.mask[d[4:0]])) begin
          push_result(KindAcked, tbl_seq[i], tbl_handle[i], tbl_size[i],
                      c.now - tbl_sent[i], 1'b0);
          drop_slot(i);  // re-examine the slot that the tail moved into
        end else begin
          i++;
        end
      end
    end else if (c.op == OpTick) begin
      while (i < tbl_count) begin
        age = c.now - tbl_sent[i];
        if (age > {16'd0, timeout_reg}) begin
          n = {1'b0, tbl_retries[i]} + 5'd1;
          if (n > {1'b0, retries_reg}) begin
            push_result(KindGivenUp, tbl_seq[i], tbl_handle[i], tbl_size[i],
                        '0, 1'b0);
            drop_slot(i);
            continue;
          end
          tbl_sent[i] = c.now;
          tbl_retries[i] = n[3:0];
          push_result(KindResend, tbl_seq[i], tbl_handle[i], tbl_size[i],
                      '0, 1'b0);
        end
        i++;
      end
    end
    push_result(KindDone, '0, '0, '0, '0, 1'b1);
  endfunction

  // Driver: present words at the falling edge.
  always @(negedge clk_i) begin
    cmd_word_t c;
    logic nxt_start;
    nxt_start = start;
    if (rst_ni) begin
      if (taken) begin
        taken = 1'b0;
        nxt_start = 1'b0;
      end
      if (!nxt_start && cmd_queue.size() > 0 &&
          $urandom_range(99, 0) >= idle_pct) begin
        c = cmd_queue.pop_front();
        opcode_i <= c.op;
        now_ms_i <= c.now;
        sequence_number_i <= c.seq;
        payload_handle_i <= c.handle;
        payload_size_i <= c.size;
        ack_number_i <= c.ack;
        ack_mask_i <= c.mask;
        nxt_start = 1'b1;
      end
    end
    start <= nxt_start;
  end

  // Monitor: take commands and check results at the rising edge.
  always @(posedge clk_i) begin
    cmd_word_t c;
    result_word_t w;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d", kind_o));
        end else begin
          w = expected_results.pop_front();
          if (kind_o !== w.kind || entry_sequence_o !== w.seq ||
              entry_handle_o !== w.handle || entry_size_o !== w.size ||
              round_trip_ms_o !== w.rtt || last_o !== w.last)
            report_mismatch($sformatf(
              "got k%0d s%h h%h z%0d r%0d l%b, want k%0d s%h h%h z%0d r%0d l%b",
              kind_o, entry_sequence_o, entry_handle_o, entry_size_o,
              round_trip_ms_o, last_o, w.kind, w.seq, w.handle, w.size,
              w.rtt, w.last));
        end
      end
      if (start && !busy) begin
        c.op = opcode_i; c.now = now_ms_i; c.seq = sequence_number_i;
        c.handle = payload_handle_i; c.size = payload_size_i;
        c.ack = ack_number_i; c.mask = ack_mask_i;
        predict_table(c);
        taken = 1'b1;
      end
    end
  end

  function automatic void add_cmd(input logic [1:0] op, input logic [31:0] now,
                                  input logic [15:0] s, input logic [15:0] h,
                                  input logic [10:0] z, input logic [15:0] a,
                                  input logic [31:0] m);
    cmd_word_t c;
    c.op = op; c.now = now; c.seq = s; c.handle = h; c.size = z;
    c.ack = a; c.mask = m;
    cmd_queue.push_back(c);
  endfunction

  task automatic wait_idle();
    while (cmd_queue.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == AddrTimeout) timeout_reg = data[15:0];
    else retries_reg = data[3:0];
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Mostly well-formed traffic: fresh sequences, acks near the head,
  // ticks after the clock has moved on; a little noise.
  task automatic gen_traffic(input int unsigned n);
    int unsigned r;
    logic [31:0] m;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(99, 0);
      clock_ms += $urandom_range(timeout_reg / 4 + 1, 0);
      case ($urandom_range(3, 0))
        0: m = $urandom();
        1: m = 32'hFFFF_FFFF;
        2: m = '0;
        default: m = $urandom() & $urandom();
      endcase
      if (r < 45) begin
        add_cmd(OpSend, clock_ms, next_seq, 16'($urandom()),
                11'($urandom_range(2047, 0)), 16'($urandom()), $urandom());
        next_seq++;
      end else if (r < 70) begin
        add_cmd(OpAck, clock_ms, 16'($urandom()), 16'($urandom()),
                11'($urandom()), next_seq - 16'($urandom_range(36, 1)), m);
      end else if (r < 90) begin
        if ($urandom_range(1, 0)) clock_ms += timeout_reg + $urandom_range(3, 0);
        add_cmd(OpTick, clock_ms, 16'($urandom()), 16'($urandom()),
                11'($urandom()), 16'($urandom()), $urandom());
      end else if (r < 95) begin
        add_cmd(OpUnused, $urandom(), 16'($urandom()), 16'($urandom()),
                11'($urandom()), 16'($urandom()), $urandom());
      end else begin
        add_cmd(OpAck, clock_ms, 16'($urandom()), 16'($urandom()),
                11'($urandom()), 16'($urandom()), $urandom());
      end
    end
  endtask

  initial begin
    clock_ms = 32'd1000;
    next_seq = 16'hFFF8;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, a full table, wrap of sequence and time.
    add_cmd(OpSend, 32'hFFFF_FFF0, 16'h0000, 16'hFFFF, 11'd2047, '0, '0);
    add_cmd(OpSend, 32'hFFFF_FFF8, 16'hFFFF, 16'h0000, 11'd0, '0, '0);
    for (int unsigned k = 0; k < PendingDepth; k++)
      add_cmd(OpSend, 32'd5 + k, 16'h0100 + 16'(k), 16'(k), 11'(k), '0, '0);
    add_cmd(OpAck, 32'd20, '0, '0, '0, 16'h0000, 32'h0000_0002);  // zero distance, wraps
    add_cmd(OpAck, 32'd30, '0, '0, '0, 16'h011F, 32'h8000_0000);  // distance 31
    add_cmd(OpAck, 32'd31, '0, '0, '0, 16'h0121, 32'hFFFF_FFFF);  // distance 32 misses
    add_cmd(OpUnused, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 11'd2047, 16'hFFFF,
            32'hFFFF_FFFF);
    add_cmd(OpTick, 32'd100, '0, '0, '0, '0, '0);
    add_cmd(OpTick, 32'd500, '0, '0, '0, '0, '0);
    add_cmd(OpAck, 32'd600, '0, '0, '0, 16'h010F, 32'hFFFF_FFFF);
    wait_idle();

    write_reg(AddrTimeout, 32'd1);
    write_reg(AddrRetries, 32'd0);
    idle_pct = 0;
    gen_traffic(90);
    wait_idle();

    write_reg(AddrTimeout, 32'd65535);
    write_reg(AddrRetries, 32'd14);
    clock_ms = 32'hFFF0_0000;
    idle_pct = 88;
    gen_traffic(60);
    // Hold off until every result is in, then resume.
    wait_idle();
    gen_traffic(40);
    wait_idle();

    write_reg(AddrTimeout, 32'd50);
    write_reg(AddrRetries, 32'd3);
    next_seq = 16'($urandom());
    idle_pct = 37;
    gen_traffic(95);
    wait_idle();

    write_reg(AddrTimeout, 32'd100);
    write_reg(AddrRetries, 32'd10);
    idle_pct = 0;
    gen_traffic(95);
    wait_idle();

    if (mismatches == 0 && expected_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/rprt_pkg.sv
src/rprt_front.sv
src/rprt_back.sv
src/reliable_packet_retry_tracker_unit.sv
verif/testbench.sv
